FILE: rtl/gray_binomial_reduce_4x4_unit_defines.svh
// assertion helpers for the reduce unit, clocked on clk and held off during rst
`ifndef GRAY_BINOMIAL_REDUCE_4X4_UNIT_DEFINES_SVH
`define GRAY_BINOMIAL_REDUCE_4X4_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define GBR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GBR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbr_pkg.sv
package gbr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_LEN   = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = $clog2(LINE_LEN);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;

  localparam int PIX_W      = 8;
  localparam int HS_W       = 11;
  localparam int VS_W       = 15;
  localparam int RND_SHIFT  = 6;
  localparam int RND_BIAS   = 32;

  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 15;

  localparam int NLANE      = 3;
  localparam int LANE_IDX_W = $clog2(NLANE);

  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int SRC_WIDTH_W  = 13;
  localparam int SRC_HEIGHT_W = 16;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT
  } cfg_reg_t;

  // horizontal sums of the three previous rows for one output column
  typedef logic [NLANE-1:0][HS_W-1:0] lanes_t;

  // one line memory access and the result it may produce
  typedef struct packed {
    logic [ADDR_W-1:0]     x;
    logic [OUT_ROW_W-1:0]  y;
    logic [HS_W-1:0]       hs;
    logic [1:0]            e;
    logic [1:0]            rlim;
    logic [LANE_IDX_W-1:0] rmod3;
    logic                  emit;
    logic                  last;
  } job_t;

  function automatic logic [1:0] tap_weight(input logic [1:0] j);
    return (j == 2'd1 || j == 2'd2) ? 2'd3 : 2'd1;
  endfunction

  // distance back from the newest sample to tap j, clamped at the frame start
  function automatic logic [1:0] tap_dist(input logic [1:0] f, input logic [1:0] j,
                                          input logic [1:0] lim);
    logic [1:0] d;
    d = (f > j) ? f - j : 2'd0;
    return (d > lim) ? lim : d;
  endfunction

  // lane holding the row d rows above the current one
  function automatic logic [LANE_IDX_W-1:0] lane_of(input logic [LANE_IDX_W-1:0] base,
                                                    input logic [1:0] d);
    logic [2:0] t;
    t = 3'(base) + 3'd3 - 3'(d);
    if (t >= 3'd3) t = t - 3'd3;
    return LANE_IDX_W'(t);
  endfunction

endpackage

FILE: rtl/gbr_if.sv
interface gbr_pix_if;
  import gbr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gbr_res_if;
  import gbr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_COL_W-1:0] out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 run_last;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input run_last, output ready);
endinterface

FILE: rtl/gbr_line_mem.sv
module gbr_line_mem (
  input  logic                              clk,
  input  logic                              en,
  input  logic [gbr_pkg::ADDR_W-1:0]        addr,
  input  logic [gbr_pkg::LANE_IDX_W-1:0]    wr_lane,
  input  logic [gbr_pkg::HS_W-1:0]          wr_data,
  output gbr_pkg::lanes_t                   rd_data
);
  import gbr_pkg::*;

  lanes_t mem [LINE_LEN];

  // read-first: the old contents of the written lane come out
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
      mem[addr][wr_lane] <= wr_data;
    end
  end

endmodule

FILE: rtl/gbr_front.sv
module gbr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [gbr_pkg::COL_W-1:0]  wlast,
  input  logic [gbr_pkg::ROW_W-1:0]  hlast,
  gbr_pix_if.sink                    pix,
  input  logic                       job_ready,
  output logic                       job_valid,
  output gbr_pkg::job_t              job
);
  import gbr_pkg::*;

  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [LANE_IDX_W-1:0] row_mod3;
  logic [PIX_W-1:0]      win [3];

  logic                  c_end, r_end, h_emit, v_emit;
  logic                  w_ge3, h_ge3, two_x_now, two_y_now;
  logic [COL_W-1:0]      xlo_full;
  logic [ROW_W-1:0]      ylo_full;
  logic [1:0]            c_lim, r_lim, f_lo, e_lo;
  logic [HS_W-1:0]       hs_now [2];
  logic [PIX_W-1:0]      tapv [4];
  logic                  take;

  logic                  s0_valid, s0_jx, s0_jy, s0_done;
  logic [HS_W-1:0]       s0_hs [2];
  logic [ADDR_W-1:0]     s0_xlo;
  logic [OUT_ROW_W-1:0]  s0_ylo;
  logic                  s0_two_x, s0_two_y, s0_emit;
  logic [1:0]            s0_e, s0_rlim;
  logic [LANE_IDX_W-1:0] s0_rmod3;

  // where this pixel sits in the frame and which outputs it completes
  always_comb begin
    c_end     = (col == wlast);
    r_end     = (row == hlast);
    h_emit    = c_end || ((col >= COL_W'(2)) && !col[0]);
    v_emit    = r_end || ((row >= ROW_W'(2)) && !row[0]);
    w_ge3     = (wlast >= COL_W'(2));
    h_ge3     = (hlast >= ROW_W'(2));
    two_x_now = c_end && !wlast[0] && w_ge3;
    two_y_now = v_emit && r_end && !hlast[0] && h_ge3;
    if (c_end) xlo_full = w_ge3 ? ((wlast - COL_W'(1)) >> 1) : '0;
    else       xlo_full = (col >> 1) - COL_W'(1);
    if (r_end) ylo_full = h_ge3 ? ((hlast - ROW_W'(1)) >> 1) : '0;
    else       ylo_full = (row >> 1) - ROW_W'(1);
    c_lim = (col >= COL_W'(3)) ? 2'd3 : col[1:0];
    r_lim = (row >= ROW_W'(3)) ? 2'd3 : row[1:0];
    f_lo  = col[1:0] - {xlo_full[0], 1'b0} + 2'd1;
    e_lo  = row[1:0] - {ylo_full[0], 1'b0} + 2'd1;
  end

  // horizontal 1,3,3,1 sums for up to two output columns
  always_comb begin
    logic [1:0]      f;
    logic [1:0]      o;
    logic [HS_W-1:0] acc;
    tapv[0] = pix.pixel_in;
    tapv[1] = win[0];
    tapv[2] = win[1];
    tapv[3] = win[2];
    for (int k = 0; k < 2; k++) begin
      f   = (k == 0) ? f_lo : f_lo - 2'd2;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        o   = tap_dist(f, 2'(i), c_lim);
        acc = acc + HS_W'(tap_weight(2'(i))) * HS_W'(tapv[o]);
      end
      hs_now[k] = acc;
    end
  end

  assign take      = pix.valid && pix.ready;
  assign s0_done   = (s0_jx == s0_two_x) && (s0_jy == s0_two_y);
  assign job_valid = s0_valid && job_ready;
  assign pix.ready = !s0_valid || (job_ready && s0_done);

  always_comb begin
    job.x     = s0_xlo + ADDR_W'(s0_jx);
    job.y     = s0_ylo + OUT_ROW_W'(s0_jy);
    job.hs    = s0_hs[s0_jx];
    job.e     = s0_jy ? s0_e - 2'd2 : s0_e;
    job.rlim  = s0_rlim;
    job.rmod3 = s0_rmod3;
    job.emit  = s0_emit;
    job.last  = s0_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_mod3 <= '0;
      s0_valid <= 1'b0;
      s0_jx    <= 1'b0;
      s0_jy    <= 1'b0;
    end else begin
      if (restart) begin
        col      <= '0;
        row      <= '0;
        row_mod3 <= '0;
      end else if (take) begin
        if (c_end) begin
          col <= '0;
          if (r_end) begin
            row      <= '0;
            row_mod3 <= '0;
          end else begin
            row      <= row + ROW_W'(1);
            row_mod3 <= (row_mod3 == LANE_IDX_W'(NLANE - 1)) ? '0
                                                               : row_mod3 + LANE_IDX_W'(1);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end

      // jobs go out column first, then row
      if (take && h_emit) begin
        s0_valid <= 1'b1;
        s0_jx    <= 1'b0;
        s0_jy    <= 1'b0;
      end else if (job_valid) begin
        if (s0_done) begin
          s0_valid <= 1'b0;
        end else if (s0_jx != s0_two_x) begin
          s0_jx <= 1'b1;
        end else begin
          s0_jx <= 1'b0;
          s0_jy <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win[2] <= win[1];
      win[1] <= win[0];
      win[0] <= pix.pixel_in;
    end
    if (take && h_emit) begin
      s0_hs[0] <= hs_now[0];
      s0_hs[1] <= hs_now[1];
      s0_xlo   <= ADDR_W'(xlo_full);
      s0_ylo   <= OUT_ROW_W'(ylo_full);
      s0_two_x <= two_x_now;
      s0_two_y <= two_y_now;
      s0_emit  <= v_emit;
      s0_e     <= e_lo;
      s0_rlim  <= r_lim;
      s0_rmod3 <= row_mod3;
    end
  end

endmodule

FILE: rtl/gbr_vert.sv
module gbr_vert (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  gbr_pkg::job_t   job,
  output logic            job_ready,
  input  gbr_pkg::lanes_t rd_data,
  gbr_res_if.source       res
);
  import gbr_pkg::*;

  logic                 s1_valid, s1_go, o_free;
  job_t                 s1_job;
  logic [VS_W-1:0]      vsum;
  logic                 o_valid, o_last;
  logic [PIX_W-1:0]     o_pix;
  logic [OUT_COL_W-1:0] o_col;
  logic [OUT_ROW_W-1:0] o_row;

  assign o_free    = !o_valid || res.ready;
  assign s1_go     = s1_valid && (!s1_job.emit || o_free);
  assign job_ready = !s1_valid || s1_go;

  // vertical 1,3,3,1 over the stored rows and the current row's sum
  always_comb begin
    logic [1:0]      d;
    logic [HS_W-1:0] v;
    vsum = VS_W'(RND_BIAS);
    for (int j = 0; j < 4; j++) begin
      d    = tap_dist(s1_job.e, 2'(j), s1_job.rlim);
      v    = (d == 2'd0) ? s1_job.hs : rd_data[lane_of(s1_job.rmod3, d)];
      vsum = vsum + VS_W'(tap_weight(2'(j))) * VS_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (job_valid)  s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;
      if (o_free) o_valid <= s1_valid && s1_job.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) s1_job <= job;
    if (o_free && s1_valid && s1_job.emit) begin
      o_pix  <= vsum[PIX_W+RND_SHIFT-1:RND_SHIFT];
      o_col  <= OUT_COL_W'(s1_job.x);
      o_row  <= s1_job.y;
      o_last <= s1_job.last;
    end
  end

  assign res.valid     = o_valid;
  assign res.pixel_out = o_pix;
  assign res.out_col   = o_col;
  assign res.out_row   = o_row;
  assign res.run_last  = o_last;

endmodule

FILE: rtl/gray_binomial_reduce_4x4_unit.sv
// channel  dir  handshake      payload
// pix      in   valid/ready    pixel_in[7:0]
// res      out  valid/ready    pixel_out[7:0] out_col[10:0] out_row[14:0] run_last
// cfg      in   cfg_wen        cfg_index[1:0] cfg_wdata[15:0]
//
// one pixel per cycle unless res stalls or a pixel makes extra accesses; a pixel that
// completes output columns makes one line memory access per (row, column) job, one a
// cycle unless res stalls, through the single port; a result passes the s1 and output
// registers; a four-result corner pixel holds the input until its last job is taken
// rst is synchronous: clears frame position and pipeline valids, sets size to 640x480;
// the line memory is not cleared
// a stalled res request backs up through the pipeline to pix.ready
`include "gray_binomial_reduce_4x4_unit_defines.svh"

module gray_binomial_reduce_4x4_unit (
  input  logic                           clk,
  input  logic                           rst,
  gbr_pix_if.sink                        pix,
  gbr_res_if.source                      res,
  input  logic                           cfg_wen,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0]      cfg_wdata
);
  import gbr_pkg::*;

  logic [COL_W-1:0]        wlast, wlast_new;
  logic [ROW_W-1:0]        hlast, hlast_new;
  logic [SRC_WIDTH_W-1:0]  src_width;
  logic [SRC_HEIGHT_W-1:0] src_height;
  logic                    restart;
  logic                    job_valid, job_ready;
  job_t                    job;
  lanes_t                  rd_data;

  assign src_width  = cfg_wdata[SRC_WIDTH_W-1:0];
  assign src_height = cfg_wdata[SRC_HEIGHT_W-1:0];

  // zero acts as one, widths beyond the line buffer clamp to it
  always_comb begin
    if (src_width == '0)                     wlast_new = '0;
    else if (32'(src_width) > MAX_WIDTH)     wlast_new = COL_W'(MAX_WIDTH - 1);
    else                                     wlast_new = COL_W'(src_width - SRC_WIDTH_W'(1));
    hlast_new = (src_height == '0) ? '0 : ROW_W'(src_height - SRC_HEIGHT_W'(1));
  end

  assign restart = cfg_wen && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      wlast <= COL_W'(RESET_WIDTH - 1);
      hlast <= ROW_W'(RESET_HEIGHT - 1);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SRC_WIDTH:  wlast <= wlast_new;
        REG_SRC_HEIGHT: hlast <= hlast_new;
        default: ;
      endcase
    end
  end

  gbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .wlast     (wlast),
    .hlast     (hlast),
    .pix       (pix),
    .job_ready (job_ready),
    .job_valid (job_valid),
    .job       (job)
  );

  gbr_line_mem u_mem (
    .clk     (clk),
    .en      (job_valid),
    .addr    (job.x),
    .wr_lane (job.rmod3),
    .wr_data (job.hs),
    .rd_data (rd_data)
  );

  gbr_vert u_vert (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .rd_data   (rd_data),
    .res       (res)
  );

  // results of one input pixel come out back to back
  `GBR_ASSERT_NEXT(a_burst_back_to_back, res.valid && res.ready && !res.run_last, res.valid, "result burst has a gap")
  // and in row, then column order
  `GBR_ASSERT_NOW(a_burst_order, res.valid && $past(res.valid && res.ready && !res.run_last), res.out_row > $past(res.out_row) || (res.out_row == $past(res.out_row) && res.out_col == OUT_COL_W'($past(res.out_col) + 1'b1)), "result burst out of order")

endmodule
